/* sv/ylrl_pkg.sv */
// shared types, register codes and marker colours for the yuv legal range limiter
`default_nettype none
package ylrl_pkg;

    localparam int unsigned NUM_LUMA = 4;

    // register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_LUMA_MIN     = 3'd0,
        REG_LUMA_MAX     = 3'd1,
        REG_CHROMA_MIN   = 3'd2,
        REG_CHROMA_MAX   = 3'd3,
        REG_SHOW_MODE    = 3'd4,
        REG_CHROMA_LAYOUT = 3'd5
    } t_reg_idx;

    // show mode codes, the remaining codes behave as clamp
    localparam logic [2:0] MODE_CLAMP       = 3'd0;
    localparam logic [2:0] MODE_LUMA        = 3'd1;
    localparam logic [2:0] MODE_LUMA_GREY   = 3'd2;
    localparam logic [2:0] MODE_CHROMA      = 3'd3;
    localparam logic [2:0] MODE_CHROMA_GREY = 3'd4;

    // layout codes, the spare code behaves as one luma
    localparam logic [1:0] LAYOUT_444 = 2'd0;
    localparam logic [1:0] LAYOUT_422 = 2'd1;
    localparam logic [1:0] LAYOUT_420 = 2'd2;

    localparam logic [7:0] LUMA_MIN_RST   = 8'd16;
    localparam logic [7:0] LUMA_MAX_RST   = 8'd235;
    localparam logic [7:0] CHROMA_MIN_RST = 8'd16;
    localparam logic [7:0] CHROMA_MAX_RST = 8'd240;

    localparam logic [7:0] GREY = 8'd128;

    typedef struct packed {
        logic [7:0] luma_min;
        logic [7:0] luma_max;
        logic [7:0] chroma_min;
        logic [7:0] chroma_max;
        logic [2:0] show_mode;
        logic [1:0] chroma_layout;
    } t_cfg;

    typedef struct packed {
        logic [NUM_LUMA-1:0][7:0] luma;
        logic [7:0]               u;
        logic [7:0]               v;
    } t_pix;

    typedef struct packed {
        logic [7:0] y;
        logic [7:0] u;
        logic [7:0] v;
    } t_colour;

    // chroma direction colours, code bit0 u low, bit1 u high, bit2 v low, bit3 v high
    // a zero y means keep the lumas
    function automatic t_colour grey_colour(input logic [3:0] code);
        t_colour c;
        case (code)
            4'd1:    c = '{y: 8'd210, u: 8'd16,  v: 8'd146};
            4'd2:    c = '{y: 8'd41,  u: 8'd240, v: 8'd110};
            4'd4:    c = '{y: 8'd170, u: 8'd165, v: 8'd16};
            4'd5:    c = '{y: 8'd153, u: 8'd49,  v: 8'd49};
            4'd6:    c = '{y: 8'd105, u: 8'd203, v: 8'd63};
            4'd8:    c = '{y: 8'd81,  u: 8'd91,  v: 8'd240};
            4'd9:    c = '{y: 8'd146, u: 8'd53,  v: 8'd193};
            4'd10:   c = '{y: 8'd106, u: 8'd202, v: 8'd222};
            default: c = '{y: 8'd0,   u: GREY,   v: GREY};
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

/* sv/ylrl_cfg.sv */
// configuration registers of the yuv legal range limiter
`default_nettype none
module ylrl_cfg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [2:0]        i_cfg_idx,
    input  wire logic [7:0]        i_cfg_data,
    output ylrl_pkg::t_cfg         o_cfg
);
    import ylrl_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_LUMA_MIN:      n_cfg.luma_min      = i_cfg_data;
                REG_LUMA_MAX:      n_cfg.luma_max      = i_cfg_data;
                REG_CHROMA_MIN:    n_cfg.chroma_min    = i_cfg_data;
                REG_CHROMA_MAX:    n_cfg.chroma_max    = i_cfg_data;
                REG_SHOW_MODE:     n_cfg.show_mode     = i_cfg_data[2:0];
                REG_CHROMA_LAYOUT: n_cfg.chroma_layout = i_cfg_data[1:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.luma_min      <= LUMA_MIN_RST;
            r_cfg.luma_max      <= LUMA_MAX_RST;
            r_cfg.chroma_min    <= CHROMA_MIN_RST;
            r_cfg.chroma_max    <= CHROMA_MAX_RST;
            r_cfg.show_mode     <= MODE_CLAMP;
            r_cfg.chroma_layout <= LAYOUT_444;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

/* sv/ylrl_calc.sv */
// range tests, clamping and marker colour selection for one macropixel
`default_nettype none
module ylrl_calc (
    input  ylrl_pkg::t_cfg i_cfg,
    input  ylrl_pkg::t_pix i_pix,
    output ylrl_pkg::t_pix o_pix
);
    import ylrl_pkg::*;

    logic [NUM_LUMA-1:0] used;
    logic [NUM_LUMA-1:0] lo;
    logic [NUM_LUMA-1:0] hi;
    logic                any_lo;
    logic                any_hi;
    logic                u_lo;
    logic                u_hi;
    logic                v_lo;
    logic                v_hi;
    t_colour             gc;

    always_comb begin
        case (i_cfg.chroma_layout)
            LAYOUT_422: used = 4'b0011;
            LAYOUT_420: used = 4'b1111;
            default:    used = 4'b0001;
        endcase
    end

    // low test wins over high when the limits are crossed
    always_comb begin
        for (int k = 0; k < NUM_LUMA; k++) begin
            lo[k] = i_pix.luma[k] < i_cfg.luma_min;
            hi[k] = !lo[k] && (i_pix.luma[k] > i_cfg.luma_max);
        end
    end

    assign any_lo = |(lo & used);
    assign any_hi = |(hi & used);
    assign u_lo   = i_pix.u < i_cfg.chroma_min;
    assign u_hi   = !u_lo && (i_pix.u > i_cfg.chroma_max);
    assign v_lo   = i_pix.v < i_cfg.chroma_min;
    assign v_hi   = !v_lo && (i_pix.v > i_cfg.chroma_max);
    assign gc     = grey_colour({v_hi, v_lo, u_hi, u_lo});

    always_comb begin
        o_pix = i_pix;
        case (i_cfg.show_mode)
            MODE_LUMA, MODE_LUMA_GREY: begin
                for (int k = 0; k < NUM_LUMA; k++) begin
                    if (used[k] && lo[k]) begin
                        o_pix.luma[k] = 8'd81;
                    end else if (used[k] && hi[k]) begin
                        o_pix.luma[k] = 8'd145;
                    end
                end
                if (any_lo && any_hi) begin
                    if (i_cfg.show_mode == MODE_LUMA) begin
                        for (int k = 0; k < NUM_LUMA; k++) begin
                            if (used[k]) begin
                                o_pix.luma[k] = 8'd210;
                            end
                        end
                        o_pix.u = 8'd16;
                        o_pix.v = 8'd146;
                    end else begin
                        o_pix.u = 8'd90;
                        o_pix.v = 8'd134;
                    end
                end else if (any_lo) begin
                    o_pix.u = 8'd91;
                    o_pix.v = 8'd240;
                end else if (any_hi) begin
                    o_pix.u = 8'd54;
                    o_pix.v = 8'd34;
                end else if (i_cfg.show_mode == MODE_LUMA_GREY) begin
                    o_pix.u = GREY;
                    o_pix.v = GREY;
                end
            end
            MODE_CHROMA: begin
                if (u_lo || u_hi || v_lo || v_hi) begin
                    for (int k = 0; k < NUM_LUMA; k++) begin
                        if (used[k]) begin
                            o_pix.luma[k] = 8'd210;
                        end
                    end
                    o_pix.u = 8'd16;
                    o_pix.v = 8'd146;
                end
            end
            MODE_CHROMA_GREY: begin
                if (gc.y != 8'd0) begin
                    for (int k = 0; k < NUM_LUMA; k++) begin
                        if (used[k]) begin
                            o_pix.luma[k] = gc.y;
                        end
                    end
                end
                o_pix.u = gc.u;
                o_pix.v = gc.v;
            end
            default: begin
                for (int k = 0; k < NUM_LUMA; k++) begin
                    if (used[k] && lo[k]) begin
                        o_pix.luma[k] = i_cfg.luma_min;
                    end else if (used[k] && hi[k]) begin
                        o_pix.luma[k] = i_cfg.luma_max;
                    end
                end
                if (u_lo) begin
                    o_pix.u = i_cfg.chroma_min;
                end else if (u_hi) begin
                    o_pix.u = i_cfg.chroma_max;
                end
                if (v_lo) begin
                    o_pix.v = i_cfg.chroma_min;
                end else if (v_hi) begin
                    o_pix.v = i_cfg.chroma_max;
                end
            end
        endcase
    end

endmodule
`default_nettype wire

/* sv/yuv_legal_range_limiter_core.sv */
// top level of the yuv legal range limiter: input register, range logic, result register
//
// Limits or marks one YUV macropixel (up to four lumas and one shared U/V
// pair) per beat. A beat accepted into the input register moves on to the
// result register when that register is free or being emptied. A new beat
// is taken in every cycle while the output is not stalled, so the throughput
// is one macropixel per clock; the figure is set by the two-stage register
// pipeline around the compare and select logic. When the output stalls, the
// result register holds its beat. An empty input register still takes one
// more beat, and the input stall rises as soon as it also holds a beat.
// Registers on the write port: 0 luma_min, 1 luma_max, 2 chroma_min,
// 3 chroma_max, 4 show_mode, 5 chroma_layout; other indexes are ignored.
// Write them only while no beat is in flight. Lumas that the layout does not
// use pass through unchanged.
`default_nettype none
module yuv_legal_range_limiter_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [2:0] i_cfg_idx,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_luma_a,
    input  wire logic [7:0] i_luma_b,
    input  wire logic [7:0] i_luma_c,
    input  wire logic [7:0] i_luma_d,
    input  wire logic [7:0] i_chroma_u,
    input  wire logic [7:0] i_chroma_v,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_out_luma_a,
    output logic [7:0]      o_out_luma_b,
    output logic [7:0]      o_out_luma_c,
    output logic [7:0]      o_out_luma_d,
    output logic [7:0]      o_out_chroma_u,
    output logic [7:0]      o_out_chroma_v
);
    import ylrl_pkg::*;

    t_cfg cfg;
    t_pix r_in_pix;
    t_pix n_out_pix;
    t_pix r_out_pix;
    logic r_in_valid;
    logic r_out_valid;
    logic advance;
    logic in_take;

    ylrl_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    ylrl_calc u_calc (
        .i_cfg (cfg),
        .i_pix (r_in_pix),
        .o_pix (n_out_pix)
    );

    // result register free or being emptied this cycle
    assign advance = !r_out_valid || !i_stall;
    assign o_stall = r_in_valid && !advance;
    assign in_take = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_pix.luma[0] <= i_luma_a;
            r_in_pix.luma[1] <= i_luma_b;
            r_in_pix.luma[2] <= i_luma_c;
            r_in_pix.luma[3] <= i_luma_d;
            r_in_pix.u       <= i_chroma_u;
            r_in_pix.v       <= i_chroma_v;
        end
        if (advance && r_in_valid) begin
            r_out_pix <= n_out_pix;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_out_luma_a   = r_out_pix.luma[0];
    assign o_out_luma_b   = r_out_pix.luma[1];
    assign o_out_luma_c   = r_out_pix.luma[2];
    assign o_out_luma_d   = r_out_pix.luma[3];
    assign o_out_chroma_u = r_out_pix.u;
    assign o_out_chroma_v = r_out_pix.v;

    // reset brings the limits back to their legal defaults
    a_cfg_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (cfg.luma_min == LUMA_MIN_RST) && (cfg.chroma_max == CHROMA_MAX_RST)
            && (cfg.show_mode == MODE_CLAMP))
        else $error("config not at reset values");

    // a held input beat is not dropped while the output is stalled
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid && r_out_valid)
        else $error("input beat lost under output stall");

    // clamp mode keeps the first luma inside well-ordered limits
    a_clamp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && cfg.show_mode == MODE_CLAMP && cfg.luma_min <= cfg.luma_max)
            |-> (o_out_luma_a >= cfg.luma_min) && (o_out_luma_a <= cfg.luma_max))
        else $error("clamped luma out of range");

    // chroma grey mode only gives grey as a u/v pair
    a_grey_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && cfg.show_mode == MODE_CHROMA_GREY && o_out_chroma_u == GREY)
            |-> (o_out_chroma_v == GREY))
        else $error("chroma grey output not a grey pair");

endmodule
`default_nettype wire
